// ----- src/imtf_pkg.sv -----
package imtf_pkg;

   // Size of the symbol list and layout of the reduction tree.
   localparam int NUM_ENTRIES = 256;
   localparam int GROUP_SIZE  = 16;
   localparam int NUM_GROUPS  = NUM_ENTRIES / GROUP_SIZE;
   localparam int ENTRY_WIDTH = 8;

   typedef logic [ENTRY_WIDTH-1:0] entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic      restore;
      logic      shift;
      entry_type rank;
      entry_type symbol;
   } cell_ctrl_type;

   // Initial order of the list: the four 32-entry quarters of the lower half appear
   // in reverse order, each keeping its inner order, and the upper half holds its own positions.
   function automatic entry_type init_entry(input entry_type pos);
      entry_type value;
      value = pos;
      if (!pos[7]) begin
         case (pos[6:5])
            2'b00:   value = {3'b011, pos[4:0]};
            2'b01:   value = {3'b010, pos[4:0]};
            2'b10:   value = {3'b001, pos[4:0]};
            default: value = {3'b000, pos[4:0]};
         endcase
      end
      return value;
   endfunction

endpackage

// ----- src/imtf_cell.sv -----
module imtf_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  imtf_pkg::entry_type      pos,
   input  imtf_pkg::cell_ctrl_type  ctrl,
   input  imtf_pkg::entry_type      prev_entry,
   output imtf_pkg::entry_type      entry,
   output imtf_pkg::entry_type      hit_value
);

   imtf_pkg::entry_type entry_ff;
   imtf_pkg::entry_type entry_in;

   // Next entry: restore the initial order, or take part in the move to front.
   // The front cell takes the symbol, cells up to the rank take their neighbour.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.restore) begin
         entry_in = imtf_pkg::init_entry(pos);
      end else if (ctrl.shift) begin
         if (pos == '0) begin
            entry_in = ctrl.symbol;
         end else if (pos <= ctrl.rank) begin
            entry_in = prev_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= imtf_pkg::init_entry(pos);
      end else begin
         entry_ff <= entry_in;
      end
   end

   // Only the cell at the requested rank offers its entry to the tree.
   assign hit_value = (pos == ctrl.rank) ? entry_ff : '0;
   assign entry     = entry_ff;

endmodule

// ----- src/imtf_tree.sv -----
module imtf_tree (
   input  logic                clock,
   input  imtf_pkg::entry_type hit_values [imtf_pkg::NUM_ENTRIES],
   output imtf_pkg::entry_type symbol
);

   imtf_pkg::entry_type group_ff [imtf_pkg::NUM_GROUPS];
   imtf_pkg::entry_type group_in [imtf_pkg::NUM_GROUPS];

   // First level: each group of cells is folded into one registered value.
   always_comb begin
      for (int g = 0; g < imtf_pkg::NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < imtf_pkg::GROUP_SIZE; k++) begin
            group_in[g] = group_in[g] | hit_values[g * imtf_pkg::GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // Second level: fold the group registers into the selected symbol.
   always_comb begin
      symbol = '0;
      for (int g = 0; g < imtf_pkg::NUM_GROUPS; g++) begin
         symbol = symbol | group_ff[g];
      end
   end

endmodule

// ----- src/inverse_move_to_front.sv -----
// Inverse move-to-front decoder over a 256-entry symbol list. Each item
// carries a rank and yields the byte held at that position; that entry then
// moves to the front and the entries before it move back one place. With
// block_start set, the initial list order is restored before the rank is
// applied. The list lives in a row of 256 cells, each holding one entry and
// handing it to its neighbour during the shift. Each item passes acceptance
// (with any restore), the registered first level of the selection tree, and
// the second level with the shift of the row; the next item is accepted only
// after that shift. Results pass through an output register, so a waiting
// result only holds back the shift of the next item, not its acceptance.
module inverse_move_to_front (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rank,
   input  logic       req_block_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_symbol
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_GATHER = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type               state_ff;
   state_type               state_in;
   imtf_pkg::entry_type     rank_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   imtf_pkg::entry_type     rsp_symbol_ff;
   imtf_pkg::entry_type     tree_symbol;
   imtf_pkg::cell_ctrl_type ctrl;
   imtf_pkg::entry_type     entries    [imtf_pkg::NUM_ENTRIES];
   imtf_pkg::entry_type     hit_values [imtf_pkg::NUM_ENTRIES];
   logic                    req_fire;
   logic                    out_free;
   logic                    update_fire;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign update_fire = (state_ff == ST_UPDATE) && out_free;

   // Sequencer for one item at a time.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_GATHER;
         ST_GATHER: state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // The output register is loaded by the shift and emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (update_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rank_ff <= req_rank;
      end
      if (update_fire) begin
         rsp_symbol_ff <= tree_symbol;
      end
   end

   // Control broadcast to the row of cells.
   assign ctrl.restore = req_fire && req_block_start;
   assign ctrl.shift   = update_fire;
   assign ctrl.rank    = rank_ff;
   assign ctrl.symbol  = tree_symbol;

   // Row of list cells; when shifting, the cells behind the front one up to the rank take their neighbour's entry.
   for (genvar i = 0; i < imtf_pkg::NUM_ENTRIES; i++) begin : g_cell
      imtf_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .pos        (imtf_pkg::entry_type'(i)),
         .ctrl       (ctrl),
         .prev_entry ((i == 0) ? imtf_pkg::entry_type'(0) : entries[(i == 0) ? 0 : i - 1]),
         .entry      (entries[i]),
         .hit_value  (hit_values[i])
      );
   end

   // Registered selection of the entry at the rank.
   imtf_tree u_tree (
      .clock      (clock),
      .hit_values (hit_values),
      .symbol     (tree_symbol)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;

endmodule
